FILE: rtl/sbdft_pkg.sv
// shared constants, register indexes and twiddle tables of the single-bin dft tone detector
package sbdft_pkg;

    localparam int SB_RING_DEPTH    = 128;
    localparam int SB_WINDOW_LENGTH = 64;
    localparam int SB_CHANNELS      = 3;

    localparam int SB_CH_W     = 2;
    localparam int SB_SAMPLE_W = 12;
    localparam int SB_X_W      = 13;
    localparam int SB_TW_W     = 16;
    localparam int SB_PROD_W   = 28;
    localparam int SB_FRAC     = 14;
    localparam int SB_LEVEL_W  = 18;
    localparam int SB_POWER_W  = 37;
    localparam int SB_CAP_W    = 7;
    localparam int SB_PH_W     = 5;
    localparam int SB_TW_STEPS = 25;
    localparam int SB_TONE_STEP = 9;

    localparam logic [SB_POWER_W-1:0] SB_POWER_MAX = '1;

    localparam logic [SB_SAMPLE_W-1:0] SB_CENTRE_A_RST = 12'd2059;
    localparam logic [SB_SAMPLE_W-1:0] SB_CENTRE_B_RST = 12'd2058;
    localparam logic [SB_SAMPLE_W-1:0] SB_CENTRE_C_RST = 12'd2053;
    localparam logic [SB_LEVEL_W-1:0]  SB_LEVEL_RST    = 18'd1500;

    localparam int SB_CFG_IDX_W = 3;
    localparam logic [SB_CFG_IDX_W-1:0] SB_REG_CENTRE_A = 3'd0;
    localparam logic [SB_CFG_IDX_W-1:0] SB_REG_CENTRE_B = 3'd1;
    localparam logic [SB_CFG_IDX_W-1:0] SB_REG_CENTRE_C = 3'd2;
    localparam logic [SB_CFG_IDX_W-1:0] SB_REG_LEVEL_A  = 3'd3;
    localparam logic [SB_CFG_IDX_W-1:0] SB_REG_LEVEL_B  = 3'd4;
    localparam logic [SB_CFG_IDX_W-1:0] SB_REG_LEVEL_C  = 3'd5;

    localparam logic [SB_CH_W-1:0] SB_CH_NONE = 2'd3;

    typedef logic signed [SB_TW_W-1:0] t_twiddle;

    // cos(2*pi*k/25) in q1.14
    function automatic t_twiddle tw_cos(input logic [SB_PH_W-1:0] ph);
        t_twiddle v;
        case (ph)
            5'd0:  v = 16'sd16384;
            5'd1:  v = 16'sd15869;
            5'd2:  v = 16'sd14357;
            5'd3:  v = 16'sd11943;
            5'd4:  v = 16'sd8779;
            5'd5:  v = 16'sd5063;
            5'd6:  v = 16'sd1029;
            5'd7:  v = -16'sd3070;
            5'd8:  v = -16'sd6976;
            5'd9:  v = -16'sd10444;
            5'd10: v = -16'sd13255;
            5'd11: v = -16'sd15233;
            5'd12: v = -16'sd16255;
            5'd13: v = -16'sd16255;
            5'd14: v = -16'sd15233;
            5'd15: v = -16'sd13255;
            5'd16: v = -16'sd10444;
            5'd17: v = -16'sd6976;
            5'd18: v = -16'sd3070;
            5'd19: v = 16'sd1029;
            5'd20: v = 16'sd5063;
            5'd21: v = 16'sd8779;
            5'd22: v = 16'sd11943;
            5'd23: v = 16'sd14357;
            5'd24: v = 16'sd15869;
            default: v = '0;
        endcase
        return v;
    endfunction

    // sin(2*pi*k/25) in q1.14
    function automatic t_twiddle tw_sin(input logic [SB_PH_W-1:0] ph);
        t_twiddle v;
        case (ph)
            5'd0:  v = 16'sd0;
            5'd1:  v = 16'sd4075;
            5'd2:  v = 16'sd7893;
            5'd3:  v = 16'sd11216;
            5'd4:  v = 16'sd13833;
            5'd5:  v = 16'sd15582;
            5'd6:  v = 16'sd16352;
            5'd7:  v = 16'sd16094;
            5'd8:  v = 16'sd14825;
            5'd9:  v = 16'sd12624;
            5'd10: v = 16'sd9630;
            5'd11: v = 16'sd6031;
            5'd12: v = 16'sd2053;
            5'd13: v = -16'sd2053;
            5'd14: v = -16'sd6031;
            5'd15: v = -16'sd9630;
            5'd16: v = -16'sd12624;
            5'd17: v = -16'sd14825;
            5'd18: v = -16'sd16094;
            5'd19: v = -16'sd16352;
            5'd20: v = -16'sd15582;
            5'd21: v = -16'sd13833;
            5'd22: v = -16'sd11216;
            5'd23: v = -16'sd7893;
            5'd24: v = -16'sd4075;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/sbdft_mul.sv
// shared dual multiplier with registered products, used for dft macs, squares and thresholds
module sbdft_mul import sbdft_pkg::*; #(
    parameter int OPW = 21
) (
    input  logic                  i_clk,
    input  logic signed [OPW-1:0] i_a0,
    input  logic signed [OPW-1:0] i_b0,
    input  logic signed [OPW-1:0] i_a1,
    input  logic signed [OPW-1:0] i_b1,
    output logic signed [2*OPW-1:0] o_p0,
    output logic signed [2*OPW-1:0] o_p1
);

    logic signed [2*OPW-1:0] r_p0;
    logic signed [2*OPW-1:0] r_p1;

    always_ff @(posedge i_clk) begin
        r_p0 <= i_a0 * i_b0;
        r_p1 <= i_a1 * i_b1;
    end

    assign o_p0 = r_p0;
    assign o_p1 = r_p1;

endmodule

FILE: rtl/single_bin_dft_tone_detector.sv
// Single-bin dft tone detector for three channels: each sample word is centred and written
// into its channel's ring, then one complex multiply-accumulate unit walks the
// WINDOW_LENGTH oldest ring entries, one ring read per cycle, and the same multipliers then
// square the two parts and the three thresholds. The single ring read port feeding the shared
// multiplier pair sets the pace: the input is not ready from the acceptance of one sample until
// its decision has been handed to the output register, so no new sample is taken before then.
// A result word may wait in the output register while the next sample is accepted. Ring
// entries never written read as zero through a per-channel full flag and write pointer, so no
// clearing pass runs after reset.
module single_bin_dft_tone_detector import sbdft_pkg::*; #(
    parameter int RING_DEPTH    = SB_RING_DEPTH,
    parameter int WINDOW_LENGTH = SB_WINDOW_LENGTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [15:0]             s_axis_tdata,   // sample[11:0]
    input  logic [SB_CH_W-1:0]      s_axis_tuser,   // channel[1:0]
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [63:0]             m_axis_tdata,   // power, capture_a, capture_b, capture_c
    output logic [3:0]              m_axis_tuser,   // channel_out[1:0], ping_start, ping_end
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [SB_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SB_LEVEL_W-1:0]   i_cfg_data
);

    localparam int PW        = $clog2(RING_DEPTH);
    localparam int MEM_DEPTH = SB_CHANNELS * RING_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int CW        = $clog2(WINDOW_LENGTH + 1);
    localparam int ACC_W     = SB_PROD_W + $clog2(WINDOW_LENGTH) + 1;
    localparam int PART_W    = ACC_W - SB_FRAC;
    localparam int OPW       = (PART_W > SB_LEVEL_W + 1) ? PART_W : SB_LEVEL_W + 1;
    localparam int PRD_W     = 2 * OPW;
    localparam int TH_W      = 2 * SB_LEVEL_W;
    localparam int WIN_MOD   = WINDOW_LENGTH % RING_DEPTH;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_PWR  = 3'd3;
    localparam logic [2:0] ST_TH   = 3'd4;
    localparam logic [2:0] ST_DEC  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    logic [SB_SAMPLE_W-1:0] r_centre [SB_CHANNELS];
    logic [SB_LEVEL_W-1:0]  r_level  [SB_CHANNELS];

    logic [PW-1:0]          r_wp    [SB_CHANNELS];
    logic                   r_full  [SB_CHANNELS];
    logic [SB_POWER_W-1:0]  r_power [SB_CHANNELS];
    logic [PW-1:0]          r_cap   [SB_CHANNELS];
    logic                   r_armed;

    logic [SB_CH_W-1:0]     r_ch;
    logic [PW-1:0]          r_ridx;
    logic [CW-1:0]          r_rd_cnt;
    logic [SB_PH_W-1:0]     r_ph;
    logic [SB_PH_W-1:0]     r_ph1;
    logic                   r_ok;
    logic                   r_v1;
    logic                   r_v2;
    logic signed [SB_X_W-1:0] r_mem_q;
    logic signed [ACC_W-1:0]  r_acc_re;
    logic signed [ACC_W-1:0]  r_acc_im;
    logic [TH_W-1:0]        r_th0;
    logic [TH_W-1:0]        r_th1;

    logic                   r_out_valid;
    logic [SB_CH_W-1:0]     r_out_ch;
    logic [SB_POWER_W-1:0]  r_out_power;
    logic                   r_out_start;
    logic                   r_out_end;
    logic [SB_CAP_W-1:0]    r_out_cap [SB_CHANNELS];

    logic signed [SB_X_W-1:0] mem [MEM_DEPTH];

    logic                   in_acc;
    logic [SB_CH_W-1:0]     ch_in;
    logic signed [SB_X_W-1:0] x_in;
    logic [PW-1:0]          wp_inc;
    logic                   wp_wrap;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic                   rd_en;
    logic [PW-1:0]          ridx_inc;
    logic [SB_PH_W-1:0]     ph_inc;
    logic signed [SB_X_W-1:0] x_rd;
    logic signed [PART_W-1:0] re_part;
    logic signed [PART_W-1:0] im_part;
    logic signed [OPW-1:0]  a0, b0, a1, b1;
    logic signed [PRD_W-1:0] p0, p1;
    logic [PRD_W:0]         pwr_sum;
    logic [SB_POWER_W-1:0]  pwr_sat;
    logic [TH_W-1:0]        th2;
    logic [SB_CHANNELS-1:0] hi;
    logic                   all_high;
    logic                   all_low;
    logic                   slot_free;
    logic                   do_out;
    logic                   do_start;
    logic                   do_end;
    logic [PW:0]            cap_sum [SB_CHANNELS];
    logic [PW-1:0]          cap_new [SB_CHANNELS];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // channel three folds onto channel 0
    assign ch_in   = (s_axis_tuser == SB_CH_NONE) ? '0 : s_axis_tuser;
    assign x_in    = $signed({1'b0, s_axis_tdata[SB_SAMPLE_W-1:0]})
                   - $signed({1'b0, r_centre[ch_in]});
    assign wp_wrap = (r_wp[ch_in] == PW'(RING_DEPTH - 1));
    assign wp_inc  = wp_wrap ? '0 : r_wp[ch_in] + PW'(1);
    assign wr_addr = AW'(ch_in) * AW'(RING_DEPTH) + AW'(r_wp[ch_in]);

    assign rd_en    = (r_state == ST_MAC) && (r_rd_cnt != CW'(WINDOW_LENGTH));
    assign rd_addr  = AW'(r_ch) * AW'(RING_DEPTH) + AW'(r_ridx);
    assign ridx_inc = (r_ridx == PW'(RING_DEPTH - 1)) ? '0 : r_ridx + PW'(1);
    assign ph_inc   = (r_ph >= SB_PH_W'(SB_TW_STEPS - SB_TONE_STEP))
                    ? r_ph - SB_PH_W'(SB_TW_STEPS - SB_TONE_STEP)
                    : r_ph + SB_PH_W'(SB_TONE_STEP);

    // never-written entries read as zero
    assign x_rd    = r_ok ? r_mem_q : '0;
    assign re_part = $signed(r_acc_re[ACC_W-1:SB_FRAC]);
    assign im_part = $signed(r_acc_im[ACC_W-1:SB_FRAC]);

    always_comb begin
        unique case (r_state)
            ST_MAC: begin
                a0 = OPW'(x_rd);
                b0 = OPW'(tw_cos(r_ph1));
                a1 = OPW'(x_rd);
                b1 = OPW'(tw_sin(r_ph1));
            end
            ST_SQ: begin
                a0 = OPW'(re_part);
                b0 = OPW'(re_part);
                a1 = OPW'(im_part);
                b1 = OPW'(im_part);
            end
            ST_PWR: begin
                a0 = $signed(OPW'(r_level[0]));
                b0 = $signed(OPW'(r_level[0]));
                a1 = $signed(OPW'(r_level[1]));
                b1 = $signed(OPW'(r_level[1]));
            end
            default: begin
                a0 = $signed(OPW'(r_level[2]));
                b0 = $signed(OPW'(r_level[2]));
                a1 = $signed(OPW'(r_level[2]));
                b1 = $signed(OPW'(r_level[2]));
            end
        endcase
    end

    sbdft_mul #(
        .OPW (OPW)
    ) u_mul (
        .i_clk (i_clk),
        .i_a0  (a0),
        .i_b0  (b0),
        .i_a1  (a1),
        .i_b1  (b1),
        .o_p0  (p0),
        .o_p1  (p1)
    );

    assign pwr_sum = {1'b0, p0} + {1'b0, p1};
    assign pwr_sat = (pwr_sum > (PRD_W + 1)'(SB_POWER_MAX)) ? SB_POWER_MAX
                                                           : pwr_sum[SB_POWER_W-1:0];
    assign th2     = p0[TH_W-1:0];

    assign hi[0]    = r_power[0] >= SB_POWER_W'(r_th0);
    assign hi[1]    = r_power[1] >= SB_POWER_W'(r_th1);
    assign hi[2]    = r_power[2] >= SB_POWER_W'(th2);
    assign all_high = &hi;
    assign all_low  = ~|hi;

    assign slot_free = !r_out_valid || m_axis_tready;
    assign do_out    = (r_state == ST_DEC) && slot_free;
    assign do_start  = do_out && r_armed && all_high;
    assign do_end    = do_out && !r_armed && all_low;

    always_comb begin
        for (int k = 0; k < SB_CHANNELS; k++) begin
            cap_sum[k] = {1'b0, r_wp[k]} + (PW + 1)'(WIN_MOD);
            cap_new[k] = (cap_sum[k] >= (PW + 1)'(RING_DEPTH))
                       ? PW'(cap_sum[k] - (PW + 1)'(RING_DEPTH)) : cap_sum[k][PW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_MAC;
            ST_MAC:  if (!rd_en && !r_v1 && !r_v2) n_state = ST_SQ;
            ST_SQ:   n_state = ST_PWR;
            ST_PWR:  n_state = ST_TH;
            ST_TH:   n_state = ST_DEC;
            ST_DEC:  if (slot_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem[wr_addr] <= x_in;
        end
        if (rd_en) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_centre[0] <= SB_CENTRE_A_RST;
            r_centre[1] <= SB_CENTRE_B_RST;
            r_centre[2] <= SB_CENTRE_C_RST;
            r_armed     <= 1'b1;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_cnt    <= '0;
            for (int k = 0; k < SB_CHANNELS; k++) begin
                r_level[k] <= SB_LEVEL_RST;
                r_wp[k]    <= '0;
                r_full[k]  <= 1'b0;
                r_power[k] <= '0;
                r_cap[k]   <= '0;
            end
        end else begin
            r_state <= n_state;
            r_v1    <= rd_en;
            r_v2    <= r_v1;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    SB_REG_CENTRE_A: r_centre[0] <= i_cfg_data[SB_SAMPLE_W-1:0];
                    SB_REG_CENTRE_B: r_centre[1] <= i_cfg_data[SB_SAMPLE_W-1:0];
                    SB_REG_CENTRE_C: r_centre[2] <= i_cfg_data[SB_SAMPLE_W-1:0];
                    SB_REG_LEVEL_A:  r_level[0]  <= i_cfg_data;
                    SB_REG_LEVEL_B:  r_level[1]  <= i_cfg_data;
                    SB_REG_LEVEL_C:  r_level[2]  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_wp[ch_in] <= wp_inc;
                if (wp_wrap) begin
                    r_full[ch_in] <= 1'b1;
                end
                r_rd_cnt <= '0;
            end else if (rd_en) begin
                r_rd_cnt <= r_rd_cnt + CW'(1);
            end

            if (r_state == ST_PWR) begin
                r_power[r_ch] <= pwr_sat;
            end

            if (do_start) begin
                r_armed <= 1'b0;
                for (int k = 0; k < SB_CHANNELS; k++) begin
                    r_cap[k] <= cap_new[k];
                end
            end else if (do_end) begin
                r_armed <= 1'b1;
            end

            if (do_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ch     <= ch_in;
            r_ridx   <= wp_inc;
            r_ph     <= '0;
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else begin
            if (rd_en) begin
                r_ridx <= ridx_inc;
                r_ph   <= ph_inc;
            end
            if (r_v2) begin
                r_acc_re <= r_acc_re + ACC_W'(p0);
                r_acc_im <= r_acc_im - ACC_W'(p1);
            end
        end
        if (rd_en) begin
            r_ph1 <= r_ph;
            r_ok  <= r_full[r_ch] || (r_ridx < r_wp[r_ch]);
        end
        if (r_state == ST_TH) begin
            r_th0 <= p0[TH_W-1:0];
            r_th1 <= p1[TH_W-1:0];
        end
        if (do_out) begin
            r_out_ch    <= r_ch;
            r_out_power <= r_power[r_ch];
            r_out_start <= do_start;
            r_out_end   <= do_end;
            for (int k = 0; k < SB_CHANNELS; k++) begin
                r_out_cap[k] <= do_start ? SB_CAP_W'(cap_new[k]) : SB_CAP_W'(r_cap[k]);
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_cap[2], r_out_cap[1], r_out_cap[0], r_out_power};
    assign m_axis_tuser  = {r_out_end, r_out_start, r_out_ch};

`ifndef SYNTHESIS
    a_accept_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_MAC))
        else $error("accepted sample did not start the window walk");

    a_start_end_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_start && r_out_end))
        else $error("ping start and ping end in one word");

    a_disarm_with_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_armed) |-> (r_out_valid && r_out_start))
        else $error("detector disarmed without a ping start word");

    a_read_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_cnt <= CW'(WINDOW_LENGTH))
        else $error("window read count overran");

    a_pointer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_wp[0]} < (PW + 1)'(RING_DEPTH))
        && ({1'b0, r_wp[1]} < (PW + 1)'(RING_DEPTH))
        && ({1'b0, r_wp[2]} < (PW + 1)'(RING_DEPTH)))
        else $error("ring write pointer out of range");
`endif

endmodule

FILE: test/single_bin_dft_tone_detector_tb.sv
// testbench for the single-bin dft tone detector with directed, tone-burst and backpressure stimulus
`timescale 1ns / 100ps

module single_bin_dft_tone_detector_tb;
    import sbdft_pkg::*;

    localparam logic [SB_CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [SB_CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam longint POWER_CEIL = (64'sd1 <<< SB_POWER_W) - 1;

    typedef struct packed {
        logic [SB_CH_W-1:0]    ch;
        logic [SB_POWER_W-1:0] power;
        logic                  start;
        logic                  stop;
        logic [SB_CAP_W-1:0]   cap_a;
        logic [SB_CAP_W-1:0]   cap_b;
        logic [SB_CAP_W-1:0]   cap_c;
    } t_tone_word;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [15:0]             s_axis_tdata = '0;   // sample[11:0]
    logic [SB_CH_W-1:0]      s_axis_tuser = '0;   // channel[1:0]
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [63:0]             m_axis_tdata;        // power, capture_a, capture_b, capture_c
    logic [3:0]              m_axis_tuser;        // channel_out[1:0], ping_start, ping_end
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [SB_CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SB_LEVEL_W-1:0]   i_cfg_data = '0;

    single_bin_dft_tone_detector i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    int cos_tab [0:24] = '{
        16384, 15869, 14357, 11943, 8779, 5063, 1029, -3070, -6976, -10444,
        -13255, -15233, -16255, -16255, -15233, -13255, -10444, -6976, -3070,
        1029, 5063, 8779, 11943, 14357, 15869
    };
    int sin_tab [0:24] = '{
        0, 4075, 7893, 11216, 13833, 15582, 16352, 16094, 14825, 12624,
        9630, 6031, 2053, -2053, -6031, -9630, -12624, -14825, -16094, -16352,
        -15582, -13833, -11216, -7893, -4075
    };

    logic [SB_SAMPLE_W-1:0]   centre_reg [0:2];
    logic [SB_LEVEL_W-1:0]    level_reg  [0:2];
    logic signed [SB_X_W-1:0] ring_mem   [0:2][0:SB_RING_DEPTH-1];
    logic [SB_CAP_W-1:0]      wr_ptr     [0:2];
    logic [SB_POWER_W-1:0]    bin_pwr    [0:2];
    logic [SB_CAP_W-1:0]      cap_idx    [0:2];
    logic                     armed_flag;

    t_tone_word predicted_words [$];
    t_tone_word want_word;
    int mismatch_count = 0;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int sink_hold = 0;

    int amp        [0:2];
    int tone_left  [0:2];
    int quiet_left [0:2];
    int tone_n     [0:2];
    int rr_ch = 0;

    function automatic logic [SB_POWER_W-1:0] bin_power_of(input int ch);
        longint re_acc, im_acc, x, sq;
        int ph;
        logic [SB_CAP_W-1:0] idx;
        re_acc = 0;
        im_acc = 0;
        ph = 0;
        for (int i = 0; i < SB_WINDOW_LENGTH; i++) begin
            idx = wr_ptr[ch] + 7'(i);
            x = longint'(ring_mem[ch][idx]);
            re_acc += x * cos_tab[ph];
            im_acc -= x * sin_tab[ph];
            ph = (ph + SB_TONE_STEP) % SB_TW_STEPS;
        end
        re_acc = re_acc >>> SB_FRAC;
        im_acc = im_acc >>> SB_FRAC;
        sq = re_acc * re_acc + im_acc * im_acc;
        if (sq > POWER_CEIL)
            sq = POWER_CEIL;
        return sq[SB_POWER_W-1:0];
    endfunction

    task automatic predict_word(input logic [SB_CH_W-1:0] ch_in, input logic [11:0] smp);
        int ch;
        logic all_high, all_low;
        longint th;
        t_tone_word w;
        ch = (ch_in == SB_CH_NONE) ? 0 : int'(ch_in);
        ring_mem[ch][wr_ptr[ch]] = $signed({1'b0, smp}) - $signed({1'b0, centre_reg[ch]});
        wr_ptr[ch] = wr_ptr[ch] + 7'd1;
        bin_pwr[ch] = bin_power_of(ch);
        all_high = 1'b1;
        all_low = 1'b1;
        for (int k = 0; k < SB_CHANNELS; k++) begin
            th = longint'(level_reg[k]) * longint'(level_reg[k]);
            if (longint'(bin_pwr[k]) >= th)
                all_low = 1'b0;
            else
                all_high = 1'b0;
        end
        w = '0;
        w.ch = 2'(ch);
        w.power = bin_pwr[ch];
        if (armed_flag) begin
            if (all_high) begin
                for (int k = 0; k < SB_CHANNELS; k++)
                    cap_idx[k] = wr_ptr[k] + 7'(SB_WINDOW_LENGTH);
                armed_flag = 1'b0;
                w.start = 1'b1;
            end
        end else if (all_low) begin
            armed_flag = 1'b1;
            w.stop = 1'b1;
        end
        w.cap_a = cap_idx[0];
        w.cap_b = cap_idx[1];
        w.cap_c = cap_idx[2];
        predicted_words.push_back(w);
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (predicted_words.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tuser, 0);
            end else begin
                want_word = predicted_words.pop_front();
                if (m_axis_tuser[1:0] !== want_word.ch)
                    report_mismatch("channel_out", m_axis_tuser[1:0], want_word.ch);
                if (m_axis_tdata[36:0] !== want_word.power)
                    report_mismatch("power", m_axis_tdata[36:0], want_word.power);
                if (m_axis_tuser[2] !== want_word.start)
                    report_mismatch("ping_start", m_axis_tuser[2], want_word.start);
                if (m_axis_tuser[3] !== want_word.stop)
                    report_mismatch("ping_end", m_axis_tuser[3], want_word.stop);
                if (m_axis_tdata[43:37] !== want_word.cap_a)
                    report_mismatch("capture_a", m_axis_tdata[43:37], want_word.cap_a);
                if (m_axis_tdata[50:44] !== want_word.cap_b)
                    report_mismatch("capture_b", m_axis_tdata[50:44], want_word.cap_b);
                if (m_axis_tdata[57:51] !== want_word.cap_c)
                    report_mismatch("capture_c", m_axis_tdata[57:51], want_word.cap_c);
                if (m_axis_tdata[63:58] !== 6'd0)
                    report_mismatch("tdata padding", m_axis_tdata[63:58], 0);
            end
        end
    end

    // receiver: long hold-off when requested, otherwise random stalls
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_sample(input logic [SB_CH_W-1:0] ch, input logic [11:0] smp);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, smp};
        s_axis_tuser  <= ch;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_word(ch, smp);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [SB_CFG_IDX_W-1:0] idx, input logic [SB_LEVEL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            SB_REG_CENTRE_A: centre_reg[0] = data[SB_SAMPLE_W-1:0];
            SB_REG_CENTRE_B: centre_reg[1] = data[SB_SAMPLE_W-1:0];
            SB_REG_CENTRE_C: centre_reg[2] = data[SB_SAMPLE_W-1:0];
            SB_REG_LEVEL_A:  level_reg[0] = data;
            SB_REG_LEVEL_B:  level_reg[1] = data;
            SB_REG_LEVEL_C:  level_reg[2] = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [11:0] tone_sample(input int ch);
        int v;
        real ang;
        if (tone_left[ch] > 0) begin
            ang = 2.0 * 3.14159265358979 * 0.36 * tone_n[ch];
            v = int'(centre_reg[ch]) + $rtoi(amp[ch] * $cos(ang)) + int'($urandom_range(16)) - 8;
            tone_n[ch]++;
            tone_left[ch]--;
            if (tone_left[ch] == 0)
                quiet_left[ch] = $urandom_range(130, 60);
        end else begin
            v = int'(centre_reg[ch]) + int'($urandom_range(6)) - 3;
            quiet_left[ch]--;
            if (quiet_left[ch] <= 0)
                tone_left[ch] = $urandom_range(140, 90);
        end
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    task automatic test_directed();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        // reset settings, channel three folds onto channel 0
        send_sample(2'd0, 12'd4095);
        send_sample(2'd1, 12'd0);
        send_sample(2'd2, 12'd2048);
        send_sample(SB_CH_NONE, 12'd4095);
        wait_idle();
        // spare indexes are ignored
        write_reg(REG_SPARE_LO, 18'h3FFFF);
        write_reg(REG_SPARE_HI, 18'h3FFFF);
        // extreme centres, zero thresholds force a ping start
        write_reg(SB_REG_CENTRE_A, 18'h3F000);
        write_reg(SB_REG_CENTRE_B, 18'h00FFF);
        write_reg(SB_REG_CENTRE_C, 18'h2A555);
        write_reg(SB_REG_LEVEL_A, 18'd0);
        write_reg(SB_REG_LEVEL_B, 18'd0);
        write_reg(SB_REG_LEVEL_C, 18'd0);
        send_sample(2'd0, 12'd4095);
        send_sample(2'd1, 12'd0);
        send_sample(2'd2, 12'd4095);
        send_sample(SB_CH_NONE, 12'd0);
        send_sample(2'd1, 12'd4095);
        wait_idle();
        // full-scale thresholds force a ping end
        write_reg(SB_REG_LEVEL_A, 18'h3FFFF);
        write_reg(SB_REG_LEVEL_B, 18'h3FFFF);
        write_reg(SB_REG_LEVEL_C, 18'h3FFFF);
        write_reg(SB_REG_CENTRE_A, 18'(SB_CENTRE_A_RST));
        write_reg(SB_REG_CENTRE_B, 18'(SB_CENTRE_B_RST));
        write_reg(SB_REG_CENTRE_C, 18'(SB_CENTRE_C_RST));
        send_sample(2'd2, 12'd0);
        send_sample(2'd0, 12'd4095);
        send_sample(2'd1, 12'hAAA);
        send_sample(2'd2, 12'h555);
        wait_idle();
        write_reg(SB_REG_LEVEL_A, SB_LEVEL_RST);
        write_reg(SB_REG_LEVEL_B, SB_LEVEL_RST);
        write_reg(SB_REG_LEVEL_C, SB_LEVEL_RST);
    endtask

    task automatic retune_detector();
        wait_idle();
        write_reg(SB_REG_CENTRE_A, 18'($urandom_range(2300, 1800)));
        write_reg(SB_REG_CENTRE_B, 18'($urandom_range(2300, 1800)));
        write_reg(SB_REG_CENTRE_C, 18'($urandom_range(2300, 1800)));
        write_reg(SB_REG_LEVEL_A, 18'(amp[0] * int'($urandom_range(40, 4))));
        write_reg(SB_REG_LEVEL_B, 18'(amp[1] * int'($urandom_range(40, 4))));
        write_reg(SB_REG_LEVEL_C, 18'(amp[2] * int'($urandom_range(40, 4))));
    endtask

    task automatic test_tone_bursts(input int src_pct, input int sink_pct, input int count);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 12) begin
                send_sample(2'($urandom_range(3)), 12'($urandom_range(4095)));
            end else begin
                send_sample(2'(rr_ch), tone_sample(rr_ch));
                rr_ch = (rr_ch + 1) % SB_CHANNELS;
            end
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        sink_hold = 400;
        for (int i = 0; i < 12; i++)
            send_sample(2'($urandom_range(3)), 12'($urandom_range(4095)));
        wait_idle();
    endtask

    initial begin
        centre_reg[0] = SB_CENTRE_A_RST;
        centre_reg[1] = SB_CENTRE_B_RST;
        centre_reg[2] = SB_CENTRE_C_RST;
        for (int k = 0; k < SB_CHANNELS; k++) begin
            level_reg[k] = SB_LEVEL_RST;
            wr_ptr[k] = '0;
            bin_pwr[k] = '0;
            cap_idx[k] = '0;
            for (int j = 0; j < SB_RING_DEPTH; j++)
                ring_mem[k][j] = '0;
            amp[k] = $urandom_range(1500, 300);
            tone_left[k] = $urandom_range(140, 90);
            quiet_left[k] = 0;
            tone_n[k] = $urandom_range(24);
        end
        armed_flag = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        retune_detector();
        test_tone_bursts(0, 0, 100);
        retune_detector();
        test_tone_bursts(76, 0, 100);
        retune_detector();
        test_tone_bursts(0, 76, 100);
        retune_detector();
        test_tone_bursts(11, 11, 75);
        test_backpressure();

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout, %0d words still expected", predicted_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
